/* rtl/hsfd_pkg.sv */
// Package for the humidity sensor frame decoder: word types and constants.
`default_nettype none

package hsfd_pkg;

  // CRC-8 over each two-byte measurement word
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within a six-byte response
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Scaling to hundredths: span * raw / 65535, then offset (temperature only)
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] TEMP_OFFSET = 17'd4500;
  localparam logic [16:0] RAW_FULL    = 17'd65535;

  // Frame queue between decoder front and scaling back
  localparam int QUEUE_DEPTH = 2;

  // One received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_word_t;

  // One decoded reading
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic               temperature_ok;
    logic        [13:0] humidity_centi;
    logic               humidity_ok;
  } reading_word_t;

  // Raw frame handed from front to back
  typedef struct packed {
    logic [15:0] temp_raw;
    logic        temp_ok;
    logic [15:0] hum_raw;
    logic        hum_ok;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/humidity_sensor_frame_decoder.sv */
// Top level of the humidity sensor frame decoder.
//
// Input channel frame_byte_valid/frame_byte_ready/frame_byte carries one byte
// word of a six-byte response: temperature high, low, check, humidity high,
// low, check. frame_start in the word forces that byte to be byte 0.
// Output channel reading_valid/reading_ready/reading carries one word per
// response: temperature and humidity in hundredths, each with a CRC-ok flag.
// A result is still delivered when a check byte mismatches.
// Throughput: one byte per cycle. frame_byte_ready drops only while the
// frame queue between decoder and scaling is full.
// After the sixth byte is taken, the reading passes the queue hop, the
// multiply stage and the divide-and-output stage.
// Stall: while reading_ready is low the output word holds, the scaling
// pipeline fills, then the queue; after QUEUE_DEPTH further frames are
// pending the byte side stalls too.
// Reset (rst, synchronous): byte position to 0, CRC to 0xFF, queue and
// pipeline emptied.
`default_nettype none

module humidity_sensor_frame_decoder #(
  parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        frame_byte_valid,
  output logic                       frame_byte_ready,
  input  wire hsfd_pkg::byte_word_t  frame_byte,
  output logic                       reading_valid,
  input  wire                        reading_ready,
  output hsfd_pkg::reading_word_t    reading
);
  import hsfd_pkg::*;

  logic   q_full;
  logic   q_not_empty;
  logic   q_push;
  logic   q_pop;
  frame_t q_in;
  frame_t q_out;

  // Decoder front
  hsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (frame_byte_valid),
    .byte_ready (frame_byte_ready),
    .byte_word  (frame_byte),
    .queue_full (q_full),
    .push       (q_push),
    .push_frame (q_in)
  );

  // Frame queue
  hsfd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (q_in),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .pop_frame  (q_out)
  );

  // Scaling back
  hsfd_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (q_not_empty),
    .pop           (q_pop),
    .frame         (q_out),
    .reading_valid (reading_valid),
    .reading_ready (reading_ready),
    .reading       (reading)
  );

endmodule

`default_nettype wire

/* rtl/hsfd_front.sv */
// Decoder front: tracks byte position, runs CRC-8, assembles raw frames.
`default_nettype none

module hsfd_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     byte_valid,
  output logic                    byte_ready,
  input  wire hsfd_pkg::byte_word_t byte_word,
  input  wire                     queue_full,
  output logic                    push,
  output hsfd_pkg::frame_t        push_frame
);
  import hsfd_pkg::*;

  // MSB-first CRC-8 of one byte, no reflection
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [2:0]  pos;
  logic [7:0]  crc;
  logic [15:0] temp_word;
  logic        temp_ok;
  logic [15:0] hum_word;

  logic [2:0]  pos_eff;
  logic        accept;
  logic [7:0]  b;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_word.rx_byte;

  // Start of response forces position zero; out-of-range positions too
  always_comb begin
    if (byte_word.frame_start || pos > POS_H_CRC) begin
      pos_eff = POS_T_HI;
    end else begin
      pos_eff = pos;
    end
  end

  // Frame push on the humidity check byte
  assign push                = accept && (pos_eff == POS_H_CRC);
  assign push_frame.temp_raw = temp_word;
  assign push_frame.temp_ok  = temp_ok;
  assign push_frame.hum_raw  = hum_word;
  assign push_frame.hum_ok   = (crc == b);

  // Position, CRC and word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_T_HI;
      crc       <= CRC_INIT;
      temp_word <= '0;
      temp_ok   <= 1'b0;
      hum_word  <= '0;
    end else if (accept) begin
      case (pos_eff)
        POS_T_HI: begin
          crc       <= crc_fold(CRC_INIT, b);
          temp_word <= {b, 8'h00};
        end
        POS_T_LO: begin
          crc       <= crc_fold(crc, b);
          temp_word <= {temp_word[15:8], b};
        end
        POS_T_CRC: begin
          temp_ok <= (crc == b);
        end
        POS_H_HI: begin
          crc      <= crc_fold(CRC_INIT, b);
          hum_word <= {b, 8'h00};
        end
        POS_H_LO: begin
          crc      <= crc_fold(crc, b);
          hum_word <= {hum_word[15:8], b};
        end
        default: begin
        end
      endcase
      pos <= (pos_eff >= POS_H_CRC) ? POS_T_HI : pos_eff + 3'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsfd_queue.sv */
// Short frame queue between decoder front and scaling back.
`default_nettype none

module hsfd_queue #(
  parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire hsfd_pkg::frame_t push_frame,
  output logic                  full,
  output logic                  not_empty,
  input  wire                   pop,
  output hsfd_pkg::frame_t      pop_frame
);
  import hsfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  frame_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_frame = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/hsfd_scale.sv */
// Scaling back: raw words to hundredths, two stages (the second ends in the output register).
`default_nettype none

module hsfd_scale (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   frame_valid,
  output logic                  pop,
  input  wire hsfd_pkg::frame_t frame,
  output logic                  reading_valid,
  input  wire                   reading_ready,
  output hsfd_pkg::reading_word_t reading
);
  import hsfd_pkg::*;

  // Stage 1: constant products
  logic        p_valid;
  logic [30:0] p_temp;
  logic [29:0] p_hum;
  logic        p_temp_ok;
  logic        p_hum_ok;

  logic        out_advance;
  logic        p_load;

  assign out_advance = !reading_valid || reading_ready;
  assign p_load      = !p_valid || out_advance;
  assign pop         = frame_valid && p_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_temp    <= 31'(frame.temp_raw) * 31'(TEMP_SPAN);
      p_hum     <= 30'(frame.hum_raw) * 30'(HUM_SPAN);
      p_temp_ok <= frame.temp_ok;
      p_hum_ok  <= frame.hum_ok;
    end
  end

  // Stage 2: divide by 65535 as hi + correction, where x = hi*65535 + (hi + lo)
  logic [14:0] t_hi;
  logic [16:0] t_rem;
  logic [16:0] t_quot;
  logic [13:0] h_hi;
  logic [16:0] h_rem;
  logic [13:0] h_quot;
  logic [16:0] t_centi;

  always_comb begin
    t_hi    = p_temp[30:16];
    t_rem   = 17'(t_hi) + 17'(p_temp[15:0]);
    t_quot  = 17'(t_hi) + ((t_rem >= RAW_FULL) ? 17'd1 : 17'd0);
    t_centi = t_quot - TEMP_OFFSET;
    h_hi    = p_hum[29:16];
    h_rem   = 17'(h_hi) + 17'(p_hum[15:0]);
    h_quot  = h_hi + ((h_rem >= RAW_FULL) ? 14'd1 : 14'd0);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reading_valid <= 1'b0;
    end else if (out_advance) begin
      reading_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && p_valid) begin
      reading.temperature_centi <= signed'(t_centi[14:0]);
      reading.temperature_ok    <= p_temp_ok;
      reading.humidity_centi    <= h_quot;
      reading.humidity_ok       <= p_hum_ok;
    end
  end

endmodule

`default_nettype wire
